>>> rtl/tsol_pkg.sv
package tsol_pkg;

  localparam int OP_W = 3;
  localparam int VAL_IN_W = 32;
  localparam int POS_W = 5;
  localparam int STAT_W = 2;
  localparam int HPOS_W = 4;
  localparam int COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_PREPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_R,
    S_INS_WRITE,
    S_SEARCH,
    S_SHIFT_L,
    S_SWAP_LO,
    S_SWAP_HI,
    S_FINISH
  } state_t;

endpackage

>>> rtl/tsol_ram.sv
module tsol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/transpose_self_organizing_list_top.sv
// Ordered list of up to CAPACITY values held in one single-port-write RAM with a
// registered read. Each item is one operation: append, prepend, insert before a
// position, erase the first match, or find; a find that hits swaps the entry
// with its predecessor. One item is worked at a time and gives one result.
// Every list access goes through the RAM at one entry per cycle. An add
// shifts the entries from the end down to the insert position up one place,
// then writes the new value; an erase or find searches from the front for
// the value, then an erase shifts the later entries down one place and a
// find hit writes the entry and its predecessor in swapped places. The result
// waits in an output register, and the next item is taken as soon as the
// result is loaded there.
module transpose_self_organizing_list_top #(
  parameter int CAPACITY = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tsol_pkg::OP_W-1:0]     operation,
  input  logic [tsol_pkg::VAL_IN_W-1:0] item_value,
  input  logic [tsol_pkg::POS_W-1:0]    position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsol_pkg::STAT_W-1:0]   status,
  output logic                          hit,
  output logic [tsol_pkg::HPOS_W-1:0]   hit_position,
  output logic [tsol_pkg::COUNT_W-1:0]  entry_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  tsol_pkg::state_t state, state_next;

  logic [CW-1:0]                   len;
  logic [tsol_pkg::OP_W-1:0]       op_r;
  logic [VALUE_WIDTH-1:0]          val_r;
  logic [tsol_pkg::STAT_W-1:0]     st_r;
  logic                            hit_r;
  logic [IW-1:0]                   where_r;
  logic [CW-1:0]                   cnt;
  logic [CW-1:0]                   ins_p;
  logic [CW-1:0]                   rk;
  logic                            cmp_valid;
  logic [IW-1:0]                   cmp_idx;
  logic [VALUE_WIDTH-1:0]          prev_data;
  logic                            wr_pend;
  logic [IW-1:0]                   pend_addr;

  logic                            wr_en;
  logic [IW-1:0]                   wr_addr;
  logic [VALUE_WIDTH-1:0]          wr_data;
  logic [IW-1:0]                   rd_addr;
  logic [VALUE_WIDTH-1:0]          rd_data;

  logic [63:0]                     in_ext;
  logic [VALUE_WIDTH-1:0]          val_in;
  logic                            accept;
  logic                            full;
  logic                            pos_over;
  logic                            search_hit;
  logic                            search_miss;
  logic                            shr_more;
  logic                            shl_more;
  logic                            out_free;
  logic [CW-1:0]                   cnt_dec;
  logic [CW:0]                     cnt_inc;
  logic [IW-1:0]                   where_dec;
  logic [IW+tsol_pkg::HPOS_W-1:0]  where_ext;
  logic [CW+tsol_pkg::COUNT_W-1:0] len_ext;

  assign in_ext = 64'(item_value);
  assign val_in = in_ext[VALUE_WIDTH-1:0];
  assign in_ready = (state == tsol_pkg::S_IDLE);
  assign accept = in_valid && in_ready;
  assign full = (len == CW'(CAPACITY));
  assign pos_over = (CW + tsol_pkg::POS_W)'(position) > (CW + tsol_pkg::POS_W)'(len);
  assign search_hit = cmp_valid && (rd_data == val_r);
  assign search_miss = !cmp_valid && (rk >= len);
  assign shr_more = (cnt > ins_p);
  assign cnt_dec = cnt - CW'(1);
  assign cnt_inc = (CW + 1)'(cnt) + (CW + 1)'(1);
  assign shl_more = (cnt_inc < (CW + 1)'(len));
  assign out_free = !out_valid || out_ready;
  assign where_dec = where_r - IW'(1);
  assign where_ext = (IW + tsol_pkg::HPOS_W)'(where_r);
  assign len_ext = (CW + tsol_pkg::COUNT_W)'(len);

  always_comb begin
    state_next = state;
    case (state)
      tsol_pkg::S_IDLE: begin
        if (in_valid) begin
          case (operation) inside
            tsol_pkg::OP_APPEND, tsol_pkg::OP_PREPEND, tsol_pkg::OP_INSERT: begin
              if (full || (operation == tsol_pkg::OP_INSERT && pos_over)) begin
                state_next = tsol_pkg::S_FINISH;
              end else begin
                state_next = tsol_pkg::S_SHIFT_R;
              end
            end
            tsol_pkg::OP_ERASE, tsol_pkg::OP_FIND: state_next = tsol_pkg::S_SEARCH;
            default: state_next = tsol_pkg::S_FINISH;
          endcase
        end
      end
      tsol_pkg::S_SHIFT_R: begin
        if (!shr_more) begin
          state_next = tsol_pkg::S_INS_WRITE;
        end
      end
      tsol_pkg::S_INS_WRITE: state_next = tsol_pkg::S_FINISH;
      tsol_pkg::S_SEARCH: begin
        if (search_hit) begin
          if (op_r == tsol_pkg::OP_ERASE) begin
            state_next = tsol_pkg::S_SHIFT_L;
          end else if (cmp_idx != '0) begin
            state_next = tsol_pkg::S_SWAP_LO;
          end else begin
            state_next = tsol_pkg::S_FINISH;
          end
        end else if (search_miss) begin
          state_next = tsol_pkg::S_FINISH;
        end
      end
      tsol_pkg::S_SHIFT_L: begin
        if (!shl_more) begin
          state_next = tsol_pkg::S_FINISH;
        end
      end
      tsol_pkg::S_SWAP_LO: state_next = tsol_pkg::S_SWAP_HI;
      tsol_pkg::S_SWAP_HI: state_next = tsol_pkg::S_FINISH;
      tsol_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = tsol_pkg::S_IDLE;
        end
      end
      default: state_next = tsol_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    wr_en = wr_pend;
    wr_addr = pend_addr;
    wr_data = rd_data;
    rd_addr = '0;
    case (state)
      tsol_pkg::S_SHIFT_R: rd_addr = cnt_dec[IW-1:0];
      tsol_pkg::S_SHIFT_L: rd_addr = cnt_inc[IW-1:0];
      tsol_pkg::S_SEARCH: rd_addr = rk[IW-1:0];
      tsol_pkg::S_INS_WRITE: begin
        wr_en = 1'b1;
        wr_addr = ins_p[IW-1:0];
        wr_data = val_r;
      end
      tsol_pkg::S_SWAP_LO: begin
        wr_en = 1'b1;
        wr_addr = where_dec;
        wr_data = val_r;
      end
      tsol_pkg::S_SWAP_HI: begin
        wr_en = 1'b1;
        wr_addr = where_r;
        wr_data = prev_data;
      end
      default: rd_addr = '0;
    endcase
  end

  tsol_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsol_pkg::S_IDLE;
      len <= '0;
      out_valid <= 1'b0;
      wr_pend <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state <= state_next;
      wr_pend <= ((state == tsol_pkg::S_SHIFT_R) && shr_more) ||
                 ((state == tsol_pkg::S_SHIFT_L) && shl_more);
      if (out_valid && out_ready && (state != tsol_pkg::S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        tsol_pkg::S_IDLE: begin
          if (accept) begin
            op_r <= operation;
            val_r <= val_in;
            hit_r <= 1'b0;
            where_r <= '0;
            cnt <= len;
            rk <= '0;
            cmp_valid <= 1'b0;
            case (operation)
              tsol_pkg::OP_APPEND: ins_p <= len;
              tsol_pkg::OP_PREPEND: ins_p <= '0;
              default: ins_p <= CW'(position);
            endcase
            if (full && (operation == tsol_pkg::OP_APPEND ||
                         operation == tsol_pkg::OP_PREPEND ||
                         operation == tsol_pkg::OP_INSERT)) begin
              st_r <= tsol_pkg::STAT_FULL;
            end else if (operation == tsol_pkg::OP_INSERT && pos_over) begin
              st_r <= tsol_pkg::STAT_RANGE;
            end else begin
              st_r <= tsol_pkg::STAT_OK;
            end
          end
        end
        tsol_pkg::S_SHIFT_R: begin
          if (shr_more) begin
            pend_addr <= cnt[IW-1:0];
            cnt <= cnt_dec;
          end
        end
        tsol_pkg::S_INS_WRITE: len <= len + CW'(1);
        tsol_pkg::S_SEARCH: begin
          if (rk < len) begin
            rk <= rk + CW'(1);
            cmp_valid <= 1'b1;
            cmp_idx <= rk[IW-1:0];
          end else begin
            cmp_valid <= 1'b0;
          end
          if (search_hit) begin
            hit_r <= 1'b1;
            where_r <= cmp_idx;
            cnt <= CW'(cmp_idx);
          end else begin
            if (cmp_valid) begin
              prev_data <= rd_data;
            end
            if (search_miss) begin
              st_r <= tsol_pkg::STAT_NOT_FOUND;
            end
          end
        end
        tsol_pkg::S_SHIFT_L: begin
          if (shl_more) begin
            pend_addr <= cnt[IW-1:0];
            cnt <= cnt_inc[CW-1:0];
          end else begin
            len <= len - CW'(1);
          end
        end
        tsol_pkg::S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status <= st_r;
            hit <= hit_r;
            hit_position <= where_ext[tsol_pkg::HPOS_W-1:0];
            entry_count <= len_ext[tsol_pkg::COUNT_W-1:0];
          end
        end
        default: cnt <= cnt;
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= CW'(CAPACITY))
    else $error("list length exceeds capacity");

  a_pend_in_shift: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (state == tsol_pkg::S_SHIFT_R || state == tsol_pkg::S_SHIFT_L))
    else $error("pending shift write outside a shift");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == tsol_pkg::S_SEARCH) |-> !wr_en)
    else $error("RAM written during search");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (status == tsol_pkg::STAT_OK))
    else $error("hit reported with a failing status");

endmodule
